[hw/rtl/tbc_pkg.sv]
// ---------------------------------------------------------------------------
// Balance controller package
// Shared types, register indexes and constants for the balance controller.
// ---------------------------------------------------------------------------
package tbc_pkg;

  localparam int unsigned GainW  = 18;
  localparam int unsigned AccW   = 64;
  localparam int unsigned FiltW  = 26;
  localparam int unsigned IntW   = 30;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 20;
  localparam logic signed [16:0] TiltLimit = 17'sd10240;

  typedef enum logic [2:0] {
    REG_UP_KP   = 3'd0,
    REG_UP_KD   = 3'd1,
    REG_SP_KP   = 3'd2,
    REG_SP_KI   = 3'd3,
    REG_TURN_KP = 3'd4,
    REG_INT_LIM = 3'd5,
    REG_SP_LIM  = 3'd6,
    REG_DUTY_LIM = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_P,
    ST_UP_D,
    ST_UP_END,
    ST_FILT,
    ST_INTEG,
    ST_SP_P,
    ST_SP_I,
    ST_SP_END,
    ST_TURN,
    ST_TURN_END,
    ST_MIX,
    ST_OUT
  } state_e;

  // Request to the serial multiplier and its status back.
  typedef struct packed {
    logic                     start;
    logic        [GainW-1:0]  gain;
    logic signed [39:0]       operand;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [AccW-1:0]   product;
  } mul_rsp_t;

endpackage

[hw/rtl/two_wheel_balance_controller.sv]
// ---------------------------------------------------------------------------
// Two-wheel balance controller
// Upright PD, speed PI and turn P loops mixed into two motor drive values.
// ---------------------------------------------------------------------------
// One item is worked on at a time: five gain products go through one
// bit-serial multiplier, the speed filter goes through a bit-serial divide
// by five, and clamping and mixing follow. A stop request skips all of this
// and answers with zeros. The result is held in an output register; the next
// item is taken once it has been taken.
module two_wheel_balance_controller
  import tbc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDatW-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [16:0]        pitch_angle_i,
  input  logic signed [15:0]        pitch_rate_i,
  input  logic signed [15:0]        yaw_rate_i,
  input  logic signed [15:0]        left_count_i,
  input  logic signed [15:0]        right_count_i,
  input  logic signed [7:0]         steer_offset_i,
  input  logic signed [15:0]        turn_target_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [14:0]               left_duty_o,
  output logic                      left_reverse_o,
  output logic [14:0]               right_duty_o,
  output logic                      right_reverse_o,
  output logic                      drive_on_o,
  output logic                      tilt_fault_o
);

  state_e state_q, state_d;

  logic [GainW-1:0] up_kp_q, up_kd_q, sp_kp_q, sp_ki_q, turn_kp_q;
  logic [19:0]      int_lim_q;
  logic [14:0]      sp_lim_q, duty_lim_q;

  logic signed [FiltW-1:0] filt_q;
  logic signed [IntW-1:0]  integ_q;

  // Latched input item.
  logic signed [16:0] pitch_q;
  logic signed [15:0] prate_q, yrate_q, lc_q, rc_q, target_q;
  logic signed [7:0]  steer_q;

  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [16:0]     up_q, up_d, turn_q, turn_d;
  logic signed [16:0]     vel_q, vel_d;
  logic signed [17:0]     left_q, left_d, right_q, right_d;

  logic [14:0] l_duty_q, r_duty_q;
  logic        l_rev_q, r_rev_q, drive_q, tilt_q, ovalid_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     div_start, div_done;
  logic signed [FiltW-1:0] div_quot;
  logic signed [31:0]      div_num;

  logic tilt;
  logic signed [AccW-1:0] sh16, sh8;
  logic signed [AccW-1:0] ilim, integ_sum, splim;
  logic signed [18:0]     mix_l, mix_r, dl;

  function automatic logic signed [AccW-1:0] shr_tz(input logic signed [AccW-1:0] v,
                                                   input int unsigned s);
    logic [AccW-1:0] m;
    begin
      m = v[AccW-1] ? AccW'(-v) : AccW'(v);
      m = m >> s;
      shr_tz = v[AccW-1] ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic logic signed [16:0] sat16(input logic signed [AccW-1:0] v);
    begin
      if (v > 64'sd32767) sat16 = 17'sd32767;
      else if (v < -64'sd32768) sat16 = -17'sd32768;
      else sat16 = 17'(v);
    end
  endfunction

  assign tilt = (pitch_q > TiltLimit) || (pitch_q < -TiltLimit);
  assign sh16 = shr_tz(acc_q + mrsp.product, 16);
  assign sh8  = shr_tz(mrsp.product, 8);
  assign ilim = $signed({36'd0, int_lim_q, 8'd0});
  assign splim = $signed({49'd0, sp_lim_q});
  assign integ_sum = AccW'(integ_q) + AccW'(filt_q) + (AccW'(steer_q) <<< 8);
  assign dl = 19'(duty_lim_q);
  assign mix_l = 19'(up_q) + 19'(vel_q) + 19'(turn_q);
  assign mix_r = 19'(up_q) + 19'(vel_q) - 19'(turn_q);
  assign div_num = (32'(lc_q) + 32'(rc_q)) * 32'sd256 + 32'(filt_q) * 32'sd4;

  assign in_ready_o  = (state_q == ST_IDLE) && !ovalid_q;
  assign cfg_ready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i && in_ready_o) state_d = req_type_i ? ST_IDLE : ST_UP_P;
      ST_UP_P:     if (mrsp.done) state_d = ST_UP_D;
      ST_UP_D:     if (mrsp.done) state_d = ST_FILT;
      ST_FILT:     if (div_done) state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_SP_P;
      ST_SP_P:     if (mrsp.done) state_d = ST_SP_I;
      ST_SP_I:     if (mrsp.done) state_d = ST_TURN;
      ST_TURN:     if (mrsp.done) state_d = ST_MIX;
      ST_MIX:      state_d = ST_OUT;
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier and divider launches.
  always_comb begin
    mreq.start   = 1'b0;
    mreq.gain    = up_kp_q;
    mreq.operand = 40'(pitch_q);
    div_start    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mreq.start = in_valid_i && in_ready_o && !req_type_i;
        mreq.operand = 40'(pitch_angle_i);
      end
      ST_UP_P: begin
        mreq.start   = mrsp.done;
        mreq.gain    = up_kd_q;
        mreq.operand = 40'(prate_q) <<< 8;
      end
      ST_UP_D:  div_start = mrsp.done;
      ST_INTEG: begin
        mreq.start   = 1'b1;
        mreq.gain    = sp_kp_q;
        mreq.operand = 40'(filt_q);
      end
      ST_SP_P: begin
        mreq.start   = mrsp.done;
        mreq.gain    = sp_ki_q;
        mreq.operand = 40'(integ_q);
      end
      ST_SP_I: begin
        mreq.start   = mrsp.done;
        mreq.gain    = turn_kp_q;
        mreq.operand = 40'(yrate_q) - 40'(target_q);
      end
      default: ;
    endcase
  end

  // Datapath updates.
  always_comb begin
    acc_d   = acc_q;
    up_d    = up_q;
    vel_d   = vel_q;
    turn_d  = turn_q;
    left_d  = left_q;
    right_d = right_q;
    unique case (state_q)
      ST_UP_P: if (mrsp.done) acc_d = mrsp.product;
      ST_UP_D: if (mrsp.done) up_d = sat16(sh16);
      ST_SP_P: if (mrsp.done) acc_d = mrsp.product;
      ST_SP_I: if (mrsp.done) begin
        if (sh16 > splim) vel_d = 17'(sp_lim_q);
        else if (sh16 < -splim) vel_d = -17'(sp_lim_q);
        else vel_d = 17'(sh16);
      end
      ST_TURN: if (mrsp.done) turn_d = sat16(sh8);
      ST_MIX: begin
        left_d  = (mix_l > dl) ? 18'(dl) : (mix_l < -dl) ? 18'(-dl) : 18'(mix_l);
        right_d = (mix_r > dl) ? 18'(dl) : (mix_r < -dl) ? 18'(-dl) : 18'(mix_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      up_kp_q    <= GainW'(117760);
      up_kd_q    <= GainW'(256);
      sp_kp_q    <= GainW'(43520);
      sp_ki_q    <= GainW'(205);
      turn_kp_q  <= GainW'(307);
      int_lim_q  <= 20'd10000;
      sp_lim_q   <= 15'd3000;
      duty_lim_q <= 15'd7000;
      filt_q     <= '0;
      integ_q    <= '0;
      ovalid_q   <= 1'b0;
      l_duty_q   <= '0;
      r_duty_q   <= '0;
      l_rev_q    <= 1'b0;
      r_rev_q    <= 1'b0;
      drive_q    <= 1'b0;
      tilt_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_UP_KP:    up_kp_q    <= cfg_data_i[GainW-1:0];
          REG_UP_KD:    up_kd_q    <= cfg_data_i[GainW-1:0];
          REG_SP_KP:    sp_kp_q    <= cfg_data_i[GainW-1:0];
          REG_SP_KI:    sp_ki_q    <= cfg_data_i[GainW-1:0];
          REG_TURN_KP:  turn_kp_q  <= cfg_data_i[GainW-1:0];
          REG_INT_LIM:  int_lim_q  <= cfg_data_i;
          REG_SP_LIM:   sp_lim_q   <= cfg_data_i[14:0];
          REG_DUTY_LIM: duty_lim_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == ST_IDLE && in_valid_i && in_ready_o && req_type_i) begin
        // A stop request clears the integral and answers with all zeros.
        integ_q  <= '0;
        ovalid_q <= 1'b1;
        l_duty_q <= '0;
        r_duty_q <= '0;
        l_rev_q  <= 1'b0;
        r_rev_q  <= 1'b0;
        drive_q  <= 1'b0;
        tilt_q   <= 1'b0;
      end
      if (state_q == ST_FILT && div_done) filt_q <= div_quot;
      if (state_q == ST_INTEG) begin
        if (integ_sum > ilim) integ_q <= IntW'(ilim);
        else if (integ_sum < -ilim) integ_q <= IntW'(-ilim);
        else integ_q <= IntW'(integ_sum);
      end
      if (state_q == ST_OUT) begin
        ovalid_q <= 1'b1;
        if (tilt) begin
          integ_q  <= '0;
          l_duty_q <= '0;
          r_duty_q <= '0;
          l_rev_q  <= 1'b0;
          r_rev_q  <= 1'b0;
          drive_q  <= 1'b0;
          tilt_q   <= 1'b1;
        end else begin
          l_rev_q  <= left_q[17];
          r_rev_q  <= right_q[17];
          l_duty_q <= left_q[17] ? 15'(-left_q) : left_q[14:0];
          r_duty_q <= right_q[17] ? 15'(-right_q) : right_q[14:0];
          drive_q  <= 1'b1;
          tilt_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && in_ready_o) begin
      pitch_q  <= pitch_angle_i;
      prate_q  <= pitch_rate_i;
      yrate_q  <= yaw_rate_i;
      lc_q     <= left_count_i;
      rc_q     <= right_count_i;
      steer_q  <= steer_offset_i;
      target_q <= turn_target_i;
    end
    acc_q   <= acc_d;
    up_q    <= up_d;
    vel_q   <= vel_d;
    turn_q  <= turn_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

  tbc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  tbc_div5 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o     = ovalid_q;
  assign left_duty_o     = l_duty_q;
  assign left_reverse_o  = l_rev_q;
  assign right_duty_o    = r_duty_q;
  assign right_reverse_o = r_rev_q;
  assign drive_on_o      = drive_q;
  assign tilt_fault_o    = tilt_q;

endmodule

[hw/rtl/tbc_serial_mul.sv]
// ---------------------------------------------------------------------------
// Bit-serial multiplier
// Multiplies a signed operand by an unsigned gain, one gain bit per cycle.
// ---------------------------------------------------------------------------
module tbc_serial_mul
  import tbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(GainW + 1);

  logic [GainW-1:0]      gain_q, gain_d;
  logic signed [AccW-1:0] mcand_q, mcand_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  always_comb begin
    gain_d  = gain_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      gain_d  = req_i.gain;
      mcand_d = AccW'(req_i.operand);
      acc_d   = '0;
      cnt_d   = CntW'(GainW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (gain_q[0]) acc_d = acc_q + mcand_q;
      gain_d  = gain_q >> 1;
      mcand_d = mcand_q <<< 1;
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q  <= gain_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

[hw/rtl/tbc_div5.sv]
// ---------------------------------------------------------------------------
// Divide by five
// Restoring division of a signed value by five, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tbc_div5
  import tbc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      num_i,
  output logic                    done_o,
  output logic signed [FiltW-1:0] quot_o
);

  localparam int unsigned NumW = 32;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [3:0]      rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NumW-1]};
    if (start_i) begin
      neg_d  = num_i[NumW-1];
      num_d  = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The quotient bits shift into the vacated low end of the dividend.
      if (trial >= 5'd5) begin
        rem_d = 4'(trial - 5'd5);
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[3:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -FiltW'(num_q) : FiltW'(num_q);

endmodule

[hw/rtl/tbc_checker.sv]
// ---------------------------------------------------------------------------
// Balance controller checker
// Port-level properties of the balance controller, bound to the top level.
// ---------------------------------------------------------------------------
module tbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [14:0] left_duty_o,
  input logic        left_reverse_o,
  input logic        drive_on_o,
  input logic        tilt_fault_o
);

  // A result that waits is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_duty_o))
    else $error("result changed while stalled");

  // No item is taken while a result waits.
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item accepted over a pending result");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_on_o && tilt_fault_o))
    else $error("drive on during tilt");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_on_o |-> left_duty_o == 15'd0 && !left_reverse_o)
    else $error("drive off with nonzero duty");

endmodule

bind two_wheel_balance_controller tbc_checker u_tbc_checker (.*);
